// ===== src/ndbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndbm_pkg
// Widths, payload types and the shared fold step for the NTT DIF butterfly.
// ----------------------------------------------------------------------------
package ndbm_pkg;

    localparam int MOD_BITS  = 52;
    localparam int LAZY_BITS = MOD_BITS + 1;

    typedef logic [MOD_BITS-1:0]  mod_t;
    typedef logic [LAZY_BITS-1:0] lazy_t;

    // modulus after reset, kept to MOD_BITS bits
    localparam mod_t MOD_RESET = MOD_BITS'(64'd3923057487904769);

    typedef struct packed {
        lazy_t upper;
        lazy_t lower;
        mod_t  twiddle;
    } operands_t;

    typedef struct packed {
        mod_t upper;
        mod_t lower;
        mod_t twiddle;
    } residues_t;

    typedef struct packed {
        lazy_t sum;
        logic  range_error;
    } side_t;

    typedef struct packed {
        lazy_t sum;
        mod_t  product;
        logic  range_error;
    } result_t;

    // t < 2p  ->  t mod p
    function automatic mod_t fold_once(input lazy_t t, input mod_t p);
        logic [LAZY_BITS:0] diff;
        diff = {1'b0, t} - {2'b00, p};
        return diff[LAZY_BITS] ? t[MOD_BITS-1:0] : diff[MOD_BITS-1:0];
    endfunction

endpackage

// ===== src/ndbm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndbm_if
// Valid/ready channels of the butterfly: operands, results, modulus write.
// ----------------------------------------------------------------------------
interface ndbm_item_if;
    logic              valid;
    logic              ready;
    ndbm_pkg::lazy_t   upper_value;
    ndbm_pkg::lazy_t   lower_value;
    ndbm_pkg::mod_t    twiddle;

    modport source (output valid, output upper_value, output lower_value,
                    output twiddle, input ready);
    modport sink   (input valid, input upper_value, input lower_value,
                    input twiddle, output ready);
endinterface

interface ndbm_result_if;
    logic              valid;
    logic              ready;
    ndbm_pkg::lazy_t   sum_out;
    ndbm_pkg::mod_t    product_out;
    logic              range_error;

    modport source (output valid, output sum_out, output product_out,
                    output range_error, input ready);
    modport sink   (input valid, input sum_out, input product_out,
                    input range_error, output ready);
endinterface

interface ndbm_cfg_if;
    logic              valid;
    logic              ready;
    ndbm_pkg::mod_t    modulus;

    modport source (output valid, output modulus, input ready);
    modport sink   (input valid, input modulus, output ready);
endinterface

// ===== src/ndbm_reduce_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndbm_reduce_pipe
// Bit-serial remainder of u, v and w by p, one operand bit per stage, MSB
// first. The first stage also forms the folded sum and the range flag.
// ----------------------------------------------------------------------------
module ndbm_reduce_pipe (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  ndbm_pkg::operands_t in_op,
    input  ndbm_pkg::mod_t      modulus,
    output logic                out_valid,
    output ndbm_pkg::residues_t out_res,
    output ndbm_pkg::side_t     out_side
);

    localparam int STEPS = ndbm_pkg::LAZY_BITS;

    typedef struct packed {
        ndbm_pkg::operands_t op;
        ndbm_pkg::residues_t res;
        ndbm_pkg::side_t     side;
    } stage_t;

    logic   valid_reg  [STEPS];
    stage_t stage_reg  [STEPS];
    stage_t stage_next [STEPS];
    stage_t first_stage;

    // sum fold and range check on the incoming item
    logic [ndbm_pkg::LAZY_BITS:0] raw_sum;
    logic [ndbm_pkg::LAZY_BITS:0] p2_ext;
    logic [ndbm_pkg::LAZY_BITS:0] folded_sum;

    always_comb
    begin
        raw_sum    = {1'b0, in_op.upper} + {1'b0, in_op.lower};
        p2_ext     = {1'b0, modulus, 1'b0};
        folded_sum = (raw_sum >= p2_ext) ? (raw_sum - p2_ext) : raw_sum;

        first_stage.op               = in_op;
        first_stage.res              = '0;
        first_stage.side.sum         = folded_sum[ndbm_pkg::LAZY_BITS-1:0];
        first_stage.side.range_error = ({1'b0, in_op.upper} >= p2_ext)
                                    || ({1'b0, in_op.lower} >= p2_ext)
                                    || (in_op.twiddle >= modulus);
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam int BIT = STEPS - 1 - k;

        stage_t          prev;
        logic            prev_valid;
        ndbm_pkg::lazy_t w_ext;

        if (k == 0)
        begin : g_head
            assign prev       = first_stage;
            assign prev_valid = in_valid;
        end
        else
        begin : g_body
            assign prev       = stage_reg[k-1];
            assign prev_valid = valid_reg[k-1];
        end

        always_comb
        begin
            w_ext                      = {1'b0, prev.op.twiddle};
            stage_next[k].op           = prev.op;
            stage_next[k].side         = prev.side;
            stage_next[k].res.upper    = ndbm_pkg::fold_once(
                {prev.res.upper, prev.op.upper[BIT]}, modulus);
            stage_next[k].res.lower    = ndbm_pkg::fold_once(
                {prev.res.lower, prev.op.lower[BIT]}, modulus);
            stage_next[k].res.twiddle  = ndbm_pkg::fold_once(
                {prev.res.twiddle, w_ext[BIT]}, modulus);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_res   = stage_reg[STEPS-1].res;
    assign out_side  = stage_reg[STEPS-1].side;

endmodule

// ===== src/ndbm_mulmod_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndbm_mulmod_pipe
// Difference stage, then shift-and-add modular multiply: per twiddle bit a
// doubling stage and a conditional add stage, each folded once by p.
// ----------------------------------------------------------------------------
module ndbm_mulmod_pipe (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  ndbm_pkg::residues_t in_res,
    input  ndbm_pkg::side_t     in_side,
    input  ndbm_pkg::mod_t      modulus,
    output logic                out_valid,
    output ndbm_pkg::result_t   out_result
);

    localparam int STEPS = 2 * ndbm_pkg::MOD_BITS;

    typedef struct packed {
        ndbm_pkg::mod_t  r;
        ndbm_pkg::mod_t  a;
        ndbm_pkg::mod_t  b;
        ndbm_pkg::side_t side;
    } stage_t;

    logic   diff_valid_reg;
    stage_t diff_reg;
    stage_t diff_next;

    logic   valid_reg  [STEPS];
    stage_t stage_reg  [STEPS];
    stage_t stage_next [STEPS];

    // d = (ur - vr) mod p
    logic [ndbm_pkg::MOD_BITS:0] diff;

    always_comb
    begin
        diff           = {1'b0, in_res.upper} - {1'b0, in_res.lower};
        diff_next.r    = '0;
        diff_next.a    = diff[ndbm_pkg::MOD_BITS]
                       ? ndbm_pkg::MOD_BITS'(in_res.upper + modulus - in_res.lower)
                       : diff[ndbm_pkg::MOD_BITS-1:0];
        diff_next.b    = in_res.twiddle;
        diff_next.side = in_side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            diff_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
        end
    end

    for (genvar j = 0; j < STEPS; j++)
    begin : g_step
        stage_t          prev;
        logic            prev_valid;
        ndbm_pkg::lazy_t acc;

        if (j == 0)
        begin : g_head
            assign prev       = diff_reg;
            assign prev_valid = diff_valid_reg;
        end
        else
        begin : g_body
            assign prev       = stage_reg[j-1];
            assign prev_valid = valid_reg[j-1];
        end

        if (j % 2 == 0)
        begin : g_double
            always_comb
            begin
                acc             = {prev.r, 1'b0};
                stage_next[j]   = prev;
                stage_next[j].r = ndbm_pkg::fold_once(acc, modulus);
            end
        end
        else
        begin : g_add
            localparam int BIT = ndbm_pkg::MOD_BITS - 1 - j / 2;

            always_comb
            begin
                acc           = {1'b0, prev.r} + {1'b0, prev.a};
                stage_next[j] = prev;
                if (prev.b[BIT])
                begin
                    stage_next[j].r = ndbm_pkg::fold_once(acc, modulus);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[j] <= stage_next[j];
            end
        end
    end

    assign out_valid              = valid_reg[STEPS-1];
    assign out_result.sum         = stage_reg[STEPS-1].side.sum;
    assign out_result.range_error = stage_reg[STEPS-1].side.range_error;
    // zero modulus: product is defined as zero
    assign out_result.product     = (modulus == '0) ? '0 : stage_reg[STEPS-1].r;

endmodule

// ===== src/ndbm_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndbm_out_buf
// Two-entry result buffer; its fill level alone sets the pipeline advance.
// ----------------------------------------------------------------------------
module ndbm_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    input  ndbm_pkg::result_t    push_result,
    output logic                 adv,
    ndbm_result_if.source        result
);

    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    ndbm_pkg::result_t head_reg;
    ndbm_pkg::result_t head_next;
    ndbm_pkg::result_t tail_reg;
    ndbm_pkg::result_t tail_next;
    logic              push;
    logic              pop;

    assign adv  = (count_reg != 2'd2);
    assign push = push_valid && adv;
    assign pop  = result.valid && result.ready;

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        unique case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    head_next = push_result;
                end
                else
                begin
                    tail_next = push_result;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                head_next  = tail_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                // only reached with one entry held
                head_next = push_result;
            end
            2'b00:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign result.valid       = (count_reg != 2'd0);
    assign result.sum_out     = head_reg.sum;
    assign result.product_out = head_reg.product;
    assign result.range_error = head_reg.range_error;

endmodule

// ===== src/ntt_dif_butterfly_modmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_dif_butterfly_modmul
// Gentleman-Sande butterfly: folded lazy sum and exact (u - v) * w mod p.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake     payload
//  -------  ---  ------------  ------------------------------------------
//  item     in   valid/ready   upper_value[53] lower_value[53] twiddle[52]
//  result   out  valid/ready   sum_out[53] product_out[52] range_error
//  cfg      in   valid/ready   modulus[52] (ready tied high)
//
//  Throughput is one item per cycle while the result buffer has room. A
//  result is offered after its item passes MOD_BITS+1 stages of
//  bit-serial remainder, one difference stage, two stages per twiddle bit
//  in the modular multiplier, and the result buffer.
//  Reset clears the valid bits and the buffer level and loads the default
//  modulus; no memory, no clearing pass.
//  Stalls: the whole pipeline advances together. item.ready drops only
//  when both result buffer entries are full, so it comes from a register.
//
// Each item goes through three parts:
//   - ndbm_reduce_pipe: u, v and w reduced mod p, one bit per stage,
//     so any p (even, tiny) and any operand bits give exact residues.
//     The folded sum and range flag ride along with the item.
//   - ndbm_mulmod_pipe: d = (ur - vr) mod p, then d * wr mod p by
//     double / conditional add, each step folded once by p.
//   - ndbm_out_buf: two-entry skid buffer in front of the result port.
//
// The modulus register feeds every stage directly; the user must rewrite it
// only while no item is in flight, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module ntt_dif_butterfly_modmul (
    input  logic          clk,
    input  logic          rst_n,
    ndbm_item_if.sink     item,
    ndbm_result_if.source result,
    ndbm_cfg_if.sink      cfg
);

    ndbm_pkg::mod_t      modulus_reg;
    logic                adv;
    ndbm_pkg::operands_t in_op;

    logic                red_valid;
    ndbm_pkg::residues_t red_res;
    ndbm_pkg::side_t     red_side;

    logic                mul_valid;
    ndbm_pkg::result_t   mul_result;

    // modulus register, always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= ndbm_pkg::MOD_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            modulus_reg <= cfg.modulus;
        end
    end

    // input side: accepted whenever the pipeline advances
    assign item.ready      = adv;
    assign in_op.upper     = item.upper_value;
    assign in_op.lower     = item.lower_value;
    assign in_op.twiddle   = item.twiddle;

    ndbm_reduce_pipe u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (item.valid),
        .in_op     (in_op),
        .modulus   (modulus_reg),
        .out_valid (red_valid),
        .out_res   (red_res),
        .out_side  (red_side)
    );

    ndbm_mulmod_pipe u_mulmod (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (red_valid),
        .in_res     (red_res),
        .in_side    (red_side),
        .modulus    (modulus_reg),
        .out_valid  (mul_valid),
        .out_result (mul_result)
    );

    // buffer level decides the advance for everything upstream
    ndbm_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_valid  (mul_valid),
        .push_result (mul_result),
        .adv         (adv),
        .result      (result)
    );

endmodule

// ===== src/ndbm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndbm_checker
// Port-level checks of the butterfly, bound to the top level.
// ----------------------------------------------------------------------------
module ndbm_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            item_valid,
    input logic            item_ready,
    input logic            cfg_valid,
    input logic            cfg_ready,
    input ndbm_pkg::mod_t  cfg_modulus,
    input logic            result_valid,
    input logic            result_ready,
    input ndbm_pkg::lazy_t sum_out,
    input ndbm_pkg::mod_t  product_out,
    input logic            range_error
);

    ndbm_pkg::mod_t  modulus_reg;
    ndbm_pkg::lazy_t twice_modulus;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= ndbm_pkg::MOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            modulus_reg <= cfg_modulus;
        end
    end

    assign twice_modulus = {modulus_reg, 1'b0};

    // a held result keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(sum_out)
            && $stable(product_out) && $stable(range_error))
        else $error("result changed while stalled");

    // product is a canonical residue
    a_product_canonical: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (modulus_reg != '0) |-> product_out < modulus_reg)
        else $error("product not below modulus");

    // zero modulus: product zero, flag raised
    a_zero_modulus: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (modulus_reg == '0) |-> (product_out == '0) && range_error)
        else $error("zero modulus result wrong");

    // in-range operands give a lazy sum below 2p
    a_sum_lazy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !range_error |-> sum_out < twice_modulus)
        else $error("sum not folded below 2p");

    // an offered item only backs up behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |-> result_valid)
        else $error("input stalled with no result waiting");

endmodule

bind ntt_dif_butterfly_modmul ndbm_checker u_ndbm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready),
    .cfg_modulus  (cfg.modulus),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .sum_out      (result.sum_out),
    .product_out  (result.product_out),
    .range_error  (result.range_error)
);

// ===== test/ntt_dif_butterfly_modmul_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_dif_butterfly_modmul_tb
// Streams DIF butterflies through the block and checks every result item.
// A queue of operand items feeds a clocked driver. A clocked monitor compares
// each result with a prediction that was made when its item was taken. The
// run steps through several moduli: reset, tiny, even, widest and random.
// Both sides idle at random, and one stretch stalls the result side long
// enough to back the pipeline up into the item port.
// ----------------------------------------------------------------------------
module ntt_dif_butterfly_modmul_tb;

    import ndbm_pkg::*;

    // pipeline depth figure; used for the final drain
    localparam int PIPE_LATENCY = 3 * MOD_BITS + 2;
    localparam int DRAIN_CYCLES = 2 * PIPE_LATENCY;
    // result side stall, well past pipe depth plus buffer
    localparam int LONG_HOLD    = 600;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    logic clk = 1'b0;
    logic rst_n;

    ndbm_item_if   item_ch ();
    ndbm_result_if result_ch ();
    ndbm_cfg_if    cfg_ch ();

    ntt_dif_butterfly_modmul i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared state
    // ------------------------------------------------------------------
    operands_t queued_operands [$];   // items not yet offered
    result_t   predicted_results [$]; // one per taken item, oldest first
    operands_t offered_op;            // item currently on the item port
    mod_t      modulus_now;           // mirror of the modulus register

    int  send_gap;
    int  recv_wait;
    bit  no_idle;                     // both sides run flat out while set
    bit  long_hold_req;               // monitor picks this up and stalls
    int  mismatch_count;
    int  cycle_count;

    // ------------------------------------------------------------------
    // Predictor: u+v folded once by 2p, (u - v + 2p) * w mod p exact,
    // range flag on any operand out of its lazy/canonical range.
    // Wide integer math stands in for the shift-and-add reduction; both
    // give the same residue for every operand.
    // ------------------------------------------------------------------
    function automatic result_t gs_butterfly(input operands_t op, input mod_t p);
        logic [63:0]  p2;
        logic [63:0]  sum_full;
        logic [63:0]  ur;
        logic [63:0]  vr;
        logic [63:0]  wr;
        logic [63:0]  diff;
        logic [127:0] prod;
        result_t      r;
        p2       = 64'(p) << 1;
        sum_full = 64'(op.upper) + 64'(op.lower);
        r.range_error = (64'(op.upper) >= p2) || (64'(op.lower) >= p2)
                        || (op.twiddle >= p);
        if (sum_full >= p2)
            sum_full = sum_full - p2;
        r.sum = sum_full[LAZY_BITS-1:0];
        if (p == '0)
        begin
            r.product = '0;
        end
        else
        begin
            ur   = 64'(op.upper) % 64'(p);
            vr   = 64'(op.lower) % 64'(p);
            wr   = 64'(op.twiddle) % 64'(p);
            // negative u - v wraps to the non-negative residue
            diff = (ur >= vr) ? (ur - vr) : (ur + (64'(p) - vr));
            prod = (128'(diff) * 128'(wr)) % 128'(p);
            r.product = prod[MOD_BITS-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 8);
    endfunction

    // lazy operand on or next to the 0 / p / 2p boundaries
    function automatic lazy_t lazy_edge(input mod_t p);
        logic [63:0] p2;
        p2 = 64'(p) << 1;
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return LAZY_BITS'(1);
            2:       return LAZY_BITS'(64'(p) - 1);
            3:       return LAZY_BITS'(p);
            4:       return LAZY_BITS'(p2 - 1);
            5:       return LAZY_BITS'(p2);
            default: return '1;
        endcase
    endfunction

    function automatic mod_t twiddle_edge(input mod_t p);
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return MOD_BITS'(1);
            2:       return p - MOD_BITS'(1);
            3:       return p;
            default: return '1;
        endcase
    endfunction

    function automatic operands_t make_op(input lazy_t u, input lazy_t v, input mod_t w);
        operands_t op;
        op.upper   = u;
        op.lower   = v;
        op.twiddle = w;
        return op;
    endfunction

    // mostly in-range butterflies, some boundary values, some raw noise
    task automatic queue_butterflies(input int count, input mod_t p);
        int          pick;
        logic [63:0] p2;
        p2 = 64'(p) << 1;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                queued_operands.push_back(make_op(LAZY_BITS'(rand_word() % p2),
                                                  LAZY_BITS'(rand_word() % p2),
                                                  MOD_BITS'(rand_word() % 64'(p))));
            else if (pick < 88)
                queued_operands.push_back(make_op(lazy_edge(p), lazy_edge(p),
                                                  twiddle_edge(p)));
            else
                queued_operands.push_back(make_op(LAZY_BITS'(rand_word()),
                                                  LAZY_BITS'(rand_word()),
                                                  MOD_BITS'(rand_word())));
        end
    endtask

    // odd modulus of random width, tiny ones included
    function automatic mod_t pick_modulus();
        logic [63:0] m;
        m = rand_word() >> $urandom_range(64 - MOD_BITS, 61);
        m = m & ((64'd1 << MOD_BITS) - 1);
        m[0] = 1'b1;
        if (m < 3)
            m = 3;
        return MOD_BITS'(m);
    endfunction

    // block is empty: nothing queued, nothing offered, nothing outstanding
    task automatic wait_idle();
        while (queued_operands.size() != 0 || item_ch.valid
               || predicted_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_modulus(input mod_t value);
        wait_idle();
        @(posedge clk);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.modulus <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        modulus_now = value;
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued items, predicts each one as it is taken,
    // then idles for a drawn number of cycles.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
                predicted_results.push_back(gs_butterfly(offered_op, modulus_now));
            if (!item_ch.valid || item_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    item_ch.valid <= 1'b0;
                end
                else if (queued_operands.size() != 0)
                begin
                    offered_op = queued_operands.pop_front();
                    item_ch.upper_value <= offered_op.upper;
                    item_ch.lower_value <= offered_op.lower;
                    item_ch.twiddle     <= offered_op.twiddle;
                    item_ch.valid       <= 1'b1;
                    send_gap = draw_gap();
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each taken result against the oldest prediction,
    // then holds ready low for a drawn wait. A long hold request from
    // the sequence overrides the wait.
    // ------------------------------------------------------------------
    result_t want;
    result_t got;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = {result_ch.sum_out, result_ch.product_out, result_ch.range_error};
                if (predicted_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result item: sum %h product %h err %b",
                                 got.sum, got.product, got.range_error);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (got.sum !== want.sum || got.product !== want.product
                        || got.range_error !== want.range_error)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("mismatch: expected %h %h %b, got %h %h %b",
                                     want.sum, want.product, want.range_error,
                                     got.sum, got.product, got.range_error);
                    end
                end
                recv_wait = draw_gap();
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                recv_wait = LONG_HOLD;
            end
            if (recv_wait > 0)
            begin
                recv_wait = recv_wait - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL ntt_dif_butterfly_modmul");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        item_ch.valid       = 1'b0;
        item_ch.upper_value = '0;
        item_ch.lower_value = '0;
        item_ch.twiddle     = '0;
        result_ch.ready     = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.modulus      = '0;
        modulus_now         = MOD_RESET;
        send_gap            = 0;
        recv_wait           = 0;
        no_idle             = 1'b0;
        long_hold_req       = 1'b0;
        mismatch_count      = 0;
        cycle_count         = 0;
        rst_n               = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner cases at the reset modulus, no write yet
        queued_operands.push_back(make_op('0, '0, '0));
        // sum folds by 2p, widest in-range operands
        queued_operands.push_back(make_op(LAZY_BITS'(2 * 64'(modulus_now) - 1),
                                          LAZY_BITS'(2 * 64'(modulus_now) - 1),
                                          modulus_now - MOD_BITS'(1)));
        // u - v negative, zero and positive
        queued_operands.push_back(make_op('0, LAZY_BITS'(2 * 64'(modulus_now) - 1),
                                          modulus_now - MOD_BITS'(1)));
        queued_operands.push_back(make_op(LAZY_BITS'(2 * 64'(modulus_now) - 1), '0,
                                          MOD_BITS'(1)));
        queued_operands.push_back(make_op(LAZY_BITS'(modulus_now),
                                          LAZY_BITS'(modulus_now),
                                          modulus_now - MOD_BITS'(1)));
        queued_operands.push_back(make_op(LAZY_BITS'(64'(modulus_now) - 1),
                                          LAZY_BITS'(modulus_now), MOD_BITS'(1)));
        queued_operands.push_back(make_op(LAZY_BITS'(1), '0, modulus_now - MOD_BITS'(1)));
        // each operand just out of range, then full-scale operand mixes
        queued_operands.push_back(make_op(LAZY_BITS'(2 * 64'(modulus_now)), '0, '0));
        queued_operands.push_back(make_op('0, LAZY_BITS'(2 * 64'(modulus_now)), '0));
        queued_operands.push_back(make_op('0, '0, modulus_now));
        queued_operands.push_back(make_op('1, '1, '1));
        queued_operands.push_back(make_op('1, '0, '1));
        queued_operands.push_back(make_op('0, '1, '1));
        queue_butterflies(300, modulus_now);

        // smallest modulus
        write_modulus(MOD_BITS'(3));
        queue_butterflies(200, modulus_now);

        // even, tiny modulus
        write_modulus(MOD_BITS'(4));
        queue_butterflies(150, modulus_now);

        // widest modulus: 2p - 1 is two below the top lazy value
        write_modulus('1);
        queue_butterflies(250, modulus_now);

        // backpressure: sender flat out into a stalled result port, so the
        // pipe fills and item.ready drops; sender has paused for all
        // results first
        wait_idle();
        no_idle       = 1'b1;
        long_hold_req = 1'b1;
        queue_butterflies(400, modulus_now);
        wait_idle();
        no_idle = 1'b0;

        write_modulus(MOD_BITS'((64'd1 << (MOD_BITS - 1)) + 1));
        queue_butterflies(200, modulus_now);

        repeat (3)
        begin
            write_modulus(pick_modulus());
            queue_butterflies(150, modulus_now);
        end

        // back to the reset value, written explicitly
        write_modulus(MOD_RESET);
        queue_butterflies(200, modulus_now);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (predicted_results.size() != 0)
        begin
            $display("%0d result items never arrived", predicted_results.size());
            mismatch_count += predicted_results.size();
        end

        if (mismatch_count == 0)
            $display("PASS ntt_dif_butterfly_modmul");
        else
            $display("FAIL ntt_dif_butterfly_modmul");
        $finish;
    end

endmodule

// ===== files.f =====
src/ndbm_pkg.sv
src/ndbm_if.sv
src/ndbm_reduce_pipe.sv
src/ndbm_mulmod_pipe.sv
src/ndbm_out_buf.sv
src/ntt_dif_butterfly_modmul.sv
src/ndbm_checker.sv
test/ntt_dif_butterfly_modmul_tb.sv
